[hw/rtl/lmss_pkg.sv]
// Package for the scrolling LED matrix scanner: command, mode and register codes,
// reset values and the row descriptor passed between the scan control and the top level.
// Depends on nothing; the scan control, the top level and the testbench import it.
package lmss_pkg;

    // Input commands.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // Scroll modes.
    localparam logic [2:0] MODE_STATIC     = 3'd0;
    localparam logic [2:0] MODE_BOTTOM_UP  = 3'd1;
    localparam logic [2:0] MODE_RIGHT_LEFT = 3'd2;
    localparam logic [2:0] MODE_LEFT_RIGHT = 3'd3;
    localparam logic [2:0] MODE_TOP_DOWN   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCROLL_MODE     = 2'd0;
    localparam logic [1:0] CFG_CHAR_COUNT      = 2'd1;
    localparam logic [1:0] CFG_FRAMES_PER_STEP = 2'd2;

    // Register reset values.
    localparam logic [2:0]  SCROLL_MODE_RESET     = MODE_STATIC;
    localparam logic [3:0]  CHAR_COUNT_RESET      = 4'd1;
    localparam logic [15:0] FRAMES_PER_STEP_RESET = 16'd200;

    localparam logic [2:0] LAST_ROW = 3'd7;

    typedef struct packed {
        logic [2:0] row;    // row being driven
        logic       last;   // row closes a frame
        logic [2:0] shift;  // bit offset of the window inside the two fetched bytes
    } t_row_info;

endpackage

[hw/rtl/lmss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/lmss_pattern_store.sv]
// Pattern store: two RAM copies written together so that two row bytes can be read
// at once, plus per-entry valid bits so that entries never loaded read as zero.
// Depends on lmss_ram.
module lmss_pattern_store #(
    parameter int MAX_CHARS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_CHARS*8)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_CHARS*8)-1:0] i_rd_addr0,
    input  logic [$clog2(MAX_CHARS*8)-1:0] i_rd_addr1,
    output logic [7:0]                     o_rd_data0,
    output logic [7:0]                     o_rd_data1
);

    localparam int DEPTH = MAX_CHARS * 8;

    logic [DEPTH-1:0] r_valid;
    logic             r_valid0;
    logic             r_valid1;
    logic [7:0]       ram_data0;
    logic [7:0]       ram_data1;

    lmss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram0 (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr0),
        .o_rd_data (ram_data0)
    );

    lmss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram1 (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr1),
        .o_rd_data (ram_data1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else if (i_rd_en) begin
            r_valid0 <= r_valid[i_rd_addr0];
            r_valid1 <= r_valid[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_valid0 ? ram_data0 : 8'h00;
    assign o_rd_data1 = r_valid1 ? ram_data1 : 8'h00;

endmodule

[hw/rtl/lmss_scan_ctrl.sv]
// Scan control: row, frame and scroll offset counters, and the store addresses of
// the window for the row being driven.
// Depends on lmss_pkg.
module lmss_scan_ctrl #(
    parameter int MAX_CHARS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick,
    input  logic                           i_stop,
    input  logic [2:0]                     i_scroll_mode,
    input  logic [3:0]                     i_char_count,
    input  logic [15:0]                    i_frames_per_step,
    output logic [$clog2(MAX_CHARS*8)-1:0] o_rd_addr0,
    output logic [$clog2(MAX_CHARS*8)-1:0] o_rd_addr1,
    output lmss_pkg::t_row_info            o_info,
    output logic                           o_blank_next
);
    import lmss_pkg::*;

    localparam int DEPTH = MAX_CHARS * 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = AW + 1;

    logic [2:0]    r_row;
    logic [15:0]   r_frame_cnt;
    logic [AW-1:0] r_offset;
    logic          r_blanked;

    logic [2:0]    n_row;
    logic [15:0]   n_frame_cnt;
    logic [AW-1:0] n_offset;
    logic          n_blanked;

    logic [3:0]    n_chars;
    logic [2:0]    mode;
    logic [XW-1:0] total;
    logic [XW-1:0] limit;
    logic [XW-1:0] off_x;
    logic [XW-1:0] eff_off;
    logic [XW-1:0] row_x;
    logic [XW-1:0] bit_pos;
    logic [XW-1:0] char0;
    logic [XW-1:0] char1;
    logic [XW-1:0] td_sum;
    logic [XW-1:0] td_idx;
    logic [XW-1:0] addr0_x;
    logic [XW-1:0] addr1_x;
    logic [XW-1:0] off_inc;
    logic [16:0]   frame_inc;
    logic [16:0]   frame_need;
    logic          is_last;

    always_comb begin
        if (i_char_count == 4'd0) begin
            n_chars = 4'd1;
        end else if (i_char_count > 4'(MAX_CHARS)) begin
            n_chars = 4'(MAX_CHARS);
        end else begin
            n_chars = i_char_count;
        end
        mode = (i_scroll_mode > MODE_TOP_DOWN) ? MODE_STATIC : i_scroll_mode;
    end

    assign total = XW'(n_chars) << 3;

    always_comb begin
        unique case (mode)
            MODE_STATIC:   limit = '0;
            MODE_TOP_DOWN: limit = total - XW'(1);
            default:       limit = total - XW'(8);
        endcase
    end

    // An offset left over from an earlier configuration restarts at zero.
    assign off_x   = XW'(r_offset);
    assign eff_off = (off_x > limit) ? '0 : off_x;
    assign row_x   = XW'(r_row);

    // Horizontal modes: the window starts bit_pos bits above the bottom of the row
    // word, in which character zero is the most significant byte.
    assign bit_pos = (mode == MODE_LEFT_RIGHT) ? (total - XW'(8) - eff_off) : eff_off;
    assign char0   = XW'(n_chars) - XW'(1) - (bit_pos >> 3);
    assign char1   = char0 - XW'(1);

    always_comb begin
        td_sum = row_x + total - eff_off;
        td_idx = (td_sum >= total) ? (td_sum - total) : td_sum;
    end

    always_comb begin
        unique case (mode)
            MODE_BOTTOM_UP:  addr0_x = eff_off + row_x;
            MODE_RIGHT_LEFT,
            MODE_LEFT_RIGHT: addr0_x = (char0 << 3) + row_x;
            MODE_TOP_DOWN:   addr0_x = td_idx;
            default:         addr0_x = row_x;
        endcase
        addr1_x = (char1 << 3) + row_x;
    end

    assign o_rd_addr0 = addr0_x[AW-1:0];
    assign o_rd_addr1 = addr1_x[AW-1:0];

    assign is_last      = (r_row == LAST_ROW);
    assign o_info.row   = r_row;
    assign o_info.last  = is_last;
    assign o_info.shift = (mode == MODE_RIGHT_LEFT || mode == MODE_LEFT_RIGHT)
                          ? bit_pos[2:0] : 3'd0;

    assign frame_inc  = {1'b0, r_frame_cnt} + 17'd1;
    assign frame_need = (i_frames_per_step == 16'd0) ? 17'd1 : {1'b0, i_frames_per_step};
    assign off_inc    = eff_off + XW'(1);

    always_comb begin
        n_row       = r_row;
        n_frame_cnt = r_frame_cnt;
        n_offset    = r_offset;
        n_blanked   = r_blanked;
        if (i_stop) begin
            n_row       = 3'd0;
            n_frame_cnt = 16'd0;
            n_offset    = '0;
            n_blanked   = 1'b1;
        end else if (i_tick) begin
            n_blanked = 1'b0;
            n_row     = r_row + 3'd1;
            n_offset  = eff_off[AW-1:0];
            if (is_last) begin
                if (frame_inc >= frame_need) begin
                    n_frame_cnt = 16'd0;
                    n_offset    = (off_inc > limit) ? '0 : off_inc[AW-1:0];
                end else begin
                    n_frame_cnt = frame_inc[15:0];
                end
            end
        end
    end

    assign o_blank_next = n_blanked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= 3'd0;
            r_frame_cnt <= 16'd0;
            r_offset    <= '0;
            r_blanked   <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_frame_cnt <= n_frame_cnt;
            r_offset    <= n_offset;
            r_blanked   <= n_blanked;
        end
    end

    // After a stop the scan restarts from the first row with no offset.
    a_stop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stop |=> (r_row == 3'd0 && r_offset == '0 && r_frame_cnt == 16'd0 && r_blanked))
        else $error("scan state not cleared after stop");

    // Apart from a stop, the frame counter moves only when a frame ends.
    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && !i_stop && !is_last) |=> (r_frame_cnt == $past(r_frame_cnt)))
        else $error("frame counter moved in the middle of a frame");

endmodule

[hw/rtl/led_matrix_scroll_scanner_unit.sv]
// Top level of the scrolling 8x8 LED matrix scanner: configuration registers,
// input handshake, pattern store, scan control and the two result stages.
// Depends on lmss_pkg, lmss_pattern_store and lmss_scan_ctrl.

// The block takes one item in every clock cycle while input stall is low. A load
// writes one row byte into the pattern store and yields nothing; a tick or a stop
// yields one row word through stage one, the registered store read, and then the
// output register. Input stall rises only when both stages hold results that the
// output side has not taken. Configuration writes are always ready; the user must
// make them while the block is idle (unenforced); writing index three has no effect.
module led_matrix_scroll_scanner_unit #(
    parameter int MAX_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_char_slot,
    input  logic [2:0]  i_char_row,
    input  logic [7:0]  i_pattern_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_shift_word,
    output logic [2:0]  o_scan_row,
    output logic        o_frame_last,
    output logic        o_display_off,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lmss_pkg::*;

    localparam int DEPTH = MAX_CHARS * 8;
    localparam int AW    = $clog2(DEPTH);

    logic [2:0]  r_scroll_mode;
    logic [3:0]  r_char_count;
    logic [15:0] r_frames_per_step;

    logic        r_s1_valid;
    t_row_info   r_s1_info;
    logic        r_s1_off;

    logic        r_out_valid;
    logic [15:0] r_out_word;
    logic [2:0]  r_out_row;
    logic        r_out_last;
    logic        r_out_off;

    logic          in_acc;
    logic          load_acc;
    logic          tick_acc;
    logic          stop_acc;
    logic          out_free;
    logic          s1_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [7:0]    rd_data0;
    logic [7:0]    rd_data1;
    t_row_info     scan_info;
    logic          blank_next;
    logic [15:0]   byte_pair;
    logic [7:0]    window;
    logic [15:0]   n_out_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_mode     <= SCROLL_MODE_RESET;
            r_char_count      <= CHAR_COUNT_RESET;
            r_frames_per_step <= FRAMES_PER_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCROLL_MODE:     r_scroll_mode     <= i_cfg_data[2:0];
                CFG_CHAR_COUNT:      r_char_count      <= i_cfg_data[3:0];
                CFG_FRAMES_PER_STEP: r_frames_per_step <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;

    assign in_acc   = i_in_valid && s1_free;
    assign load_acc = in_acc && (i_cmd == CMD_LOAD);
    assign tick_acc = in_acc && (i_cmd == CMD_TICK);
    assign stop_acc = in_acc && (i_cmd == CMD_STOP);

    // Loads into slots beyond the store are dropped.
    assign wr_en   = load_acc && ({1'b0, i_char_slot} < 4'(MAX_CHARS));
    assign wr_addr = AW'({i_char_slot, i_char_row});

    lmss_scan_ctrl #(.MAX_CHARS(MAX_CHARS)) u_scan_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tick            (tick_acc),
        .i_stop            (stop_acc),
        .i_scroll_mode     (r_scroll_mode),
        .i_char_count      (r_char_count),
        .i_frames_per_step (r_frames_per_step),
        .o_rd_addr0        (rd_addr0),
        .o_rd_addr1        (rd_addr1),
        .o_info            (scan_info),
        .o_blank_next      (blank_next)
    );

    lmss_pattern_store #(.MAX_CHARS(MAX_CHARS)) u_pattern_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (i_pattern_byte),
        .i_rd_en    (tick_acc),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    // Stage one: the store read is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= tick_acc || stop_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc || stop_acc) begin
            r_s1_info <= scan_info;
            r_s1_off  <= blank_next;
        end
    end

    // The window straddles at most two bytes; with no shift the upper one drops out.
    assign byte_pair  = {rd_data1, rd_data0} >> r_s1_info.shift;
    assign window     = byte_pair[7:0];
    assign n_out_word = {8'd1 << r_s1_info.row, ~window};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            if (r_s1_off) begin
                r_out_word <= 16'd0;
                r_out_row  <= 3'd0;
                r_out_last <= 1'b0;
            end else begin
                r_out_word <= n_out_word;
                r_out_row  <= r_s1_info.row;
                r_out_last <= r_s1_info.last;
            end
            r_out_off <= r_s1_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_shift_word  = r_out_word;
    assign o_scan_row    = r_out_row;
    assign o_frame_last  = r_out_last;
    assign o_display_off = r_out_off;

    // Every tick or stop transfer occupies stage one on the following cycle.
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && (tick_acc || stop_acc)) |=> r_s1_valid)
        else $error("accepted tick or stop did not enter stage one");

    // A blanking result carries an all-zero word on the first row.
    a_blank_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_off) |-> (r_out_word == 16'd0 && r_out_row == 3'd0 && !r_out_last))
        else $error("blanking result carries row data");

    // A driven row has its one-hot select matching the row, and only the last row ends a frame.
    a_row_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_off) |->
            (r_out_word[15:8] == (8'd1 << r_out_row) && r_out_last == (r_out_row == LAST_ROW)))
        else $error("row select or frame end inconsistent with scan row");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for led_matrix_scroll_scanner_unit: pattern loads, row ticks and stops
// pass through a handshaked stream under random sender gaps and receiver stalls.
// Depends on lmss_pkg and the RTL of the block; a class predicts and checks every row word.
`timescale 1ns / 1ps

module tb_top;
    import lmss_pkg::*;

    localparam int          STORE_CHARS   = 8;
    localparam int          SETTLE_CYCLES = 6;      // idle wait after a drain, beyond the two-stage result path
    localparam int          NUM_PHASES    = 10;
    localparam int          PHASE_ITEMS   = 93;
    localparam logic [1:0]  CMD_NONE      = 2'd3;   // command with no meaning, ignored
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;   // register index that holds nothing
    localparam logic [2:0]  MODE_UNUSED   = 3'd6;   // mode with no meaning, scanned as static

    typedef struct packed {
        logic [15:0] word;
        logic [2:0]  row;
        logic        last;
        logic        off;
    } t_row_word;

    // Predicts the row words from the accepted transfers and compares the block's output.
    class row_scan_checker;
        logic [7:0]  store [64];
        logic [2:0]  row_cnt;
        logic [15:0] frame_cnt;
        logic [5:0]  offset;
        logic        blank;
        logic [2:0]  mode_reg;
        logic [3:0]  chars_reg;
        logic [15:0] fps_reg;
        t_row_word   pending_rows [$];
        int errors, rows_checked, loads, ticks, stops, ignored, reg_writes, advances, wraps;

        function new();
            foreach (store[k]) store[k] = 8'h00;
            row_cnt   = 3'd0;
            frame_cnt = 16'd0;
            offset    = 6'd0;
            blank     = 1'b0;
            mode_reg  = SCROLL_MODE_RESET;
            chars_reg = CHAR_COUNT_RESET;
            fps_reg   = FRAMES_PER_STEP_RESET;
        endfunction

        function int pending();
            return pending_rows.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            reg_writes++;
            case (idx)
                CFG_SCROLL_MODE:     mode_reg  = data[2:0];
                CFG_CHAR_COUNT:      chars_reg = data[3:0];
                CFG_FRAMES_PER_STEP: fps_reg   = data;
                default: ;
            endcase
        endfunction

        function void predict_tick();
            int          n, total, lim, nxt, need;
            logic [2:0]  m, r;
            logic [7:0]  col, sel;
            logic [63:0] joined, shifted;
            t_row_word   res;

            n = chars_reg;
            if (n < 1) n = 1;
            if (n > STORE_CHARS) n = STORE_CHARS;
            total = 8 * n;
            m = (mode_reg <= MODE_TOP_DOWN) ? mode_reg : MODE_STATIC;
            case (m)
                MODE_STATIC:   lim = 0;
                MODE_TOP_DOWN: lim = total - 1;
                default:       lim = total - 8;
            endcase

            blank = 1'b0;
            if (int'(offset) > lim) offset = 6'd0;
            r = row_cnt;

            // Row bytes of all characters side by side, character 0 in the highest used byte.
            joined = 64'd0;
            for (int c = 0; c < n; c++) joined = {joined[55:0], store[c * 8 + int'(r)]};

            case (m)
                MODE_BOTTOM_UP:  col = store[(int'(offset) + int'(r)) % 64];
                MODE_RIGHT_LEFT: begin
                    shifted = joined >> offset;
                    col = shifted[7:0];
                end
                MODE_LEFT_RIGHT: begin
                    shifted = joined >> (total - 8 - int'(offset));
                    col = shifted[7:0];
                end
                MODE_TOP_DOWN:   col = store[(int'(r) + total - int'(offset)) % total];
                default:         col = store[r];
            endcase

            sel = 8'd1 << r;
            res.word = {sel, ~col};
            res.row  = r;
            res.last = (r == LAST_ROW);
            res.off  = 1'b0;
            pending_rows.push_back(res);

            row_cnt = r + 3'd1;
            if (r == LAST_ROW) begin
                nxt  = int'(frame_cnt) + 1;
                need = (fps_reg == 16'd0) ? 1 : int'(fps_reg);
                if (nxt >= need) begin
                    frame_cnt = 16'd0;
                    advances++;
                    if (int'(offset) + 1 > lim) begin
                        offset = 6'd0;
                        wraps++;
                    end else begin
                        offset = offset + 6'd1;
                    end
                end else begin
                    frame_cnt = 16'(nxt);
                end
            end
        endfunction

        function void note_item(logic [1:0] cmd, logic [2:0] slot, logic [2:0] row,
                                logic [7:0] pbyte);
            t_row_word res;
            case (cmd)
                CMD_LOAD: begin
                    loads++;
                    if (int'(slot) < STORE_CHARS) store[{slot, row}] = pbyte;
                end
                CMD_TICK: begin
                    ticks++;
                    predict_tick();
                end
                CMD_STOP: begin
                    stops++;
                    row_cnt   = 3'd0;
                    frame_cnt = 16'd0;
                    offset    = 6'd0;
                    blank     = 1'b1;
                    res = '{word: 16'h0000, row: 3'd0, last: 1'b0, off: 1'b1};
                    pending_rows.push_back(res);
                end
                default: ignored++;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_row(logic [15:0] word, logic [2:0] row, logic last, logic off);
            t_row_word want;
            if (pending_rows.size() == 0) begin
                report($sformatf("row word %h with no transfer waiting for it", word));
                return;
            end
            want = pending_rows.pop_front();
            if (word !== want.word)
                report($sformatf("word %0d: shift_word %h, expected %h",
                                 rows_checked, word, want.word));
            if (row !== want.row)
                report($sformatf("word %0d: scan_row %0d, expected %0d",
                                 rows_checked, row, want.row));
            if (last !== want.last)
                report($sformatf("word %0d: frame_last %b, expected %b",
                                 rows_checked, last, want.last));
            if (off !== want.off)
                report($sformatf("word %0d: display_off %b, expected %b",
                                 rows_checked, off, want.off));
            rows_checked++;
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd          = CMD_NONE;
    logic [2:0]  i_char_slot    = 3'd0;
    logic [2:0]  i_char_row     = 3'd0;
    logic [7:0]  i_pattern_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [15:0] o_shift_word;
    logic [2:0]  o_scan_row;
    logic        o_frame_last;
    logic        o_display_off;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index    = CFG_SCROLL_MODE;
    logic [15:0] i_cfg_data     = 16'h0000;

    row_scan_checker sb = new();

    led_matrix_scroll_scanner_unit #(
        .MAX_CHARS(STORE_CHARS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_char_slot    (i_char_slot),
        .i_char_row     (i_char_row),
        .i_pattern_byte (i_pattern_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_shift_word   (o_shift_word),
        .o_scan_row     (o_scan_row),
        .o_frame_last   (o_frame_last),
        .o_display_off  (o_display_off),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every transfer on the three channels is seen here, at the edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_row(o_shift_word, o_scan_row, o_frame_last, o_display_off);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_cmd, i_char_slot, i_char_row, i_pattern_byte);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Output back-pressure: the style changes every so often between none, light,
    // heavy and alternate-cycle stalling.
    int stall_style = 0;
    int stall_span  = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_span  = $urandom_range(20, 120);
            end
            stall_span = stall_span - 1;
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    task automatic drive_item(input logic [1:0] cmd, input logic [2:0] slot,
                              input logic [2:0] row, input logic [7:0] pbyte);
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_char_slot    <= slot;
        i_char_row     <= row;
        i_pattern_byte <= pbyte;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic tick_rows(input int count);
        repeat (count) drive_item(CMD_TICK, 3'($urandom), 3'($urandom), 8'($urandom));
    endtask

    // Holds the sender off until every row word that is owed has been taken.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Drain, then give a trailing load time to reach the store before registers change.
    task automatic settle_idle();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [2:0] mode, input logic [3:0] chars,
                                input logic [15:0] fps, input bit touch_unused);
        logic [1:0]  idxs [4];
        logic [15:0] vals [4];
        logic [15:0] noise;
        int          cnt;
        noise   = 16'($urandom);
        idxs[0] = CFG_SCROLL_MODE;
        vals[0] = {noise[15:3], mode};
        idxs[1] = CFG_CHAR_COUNT;
        vals[1] = {noise[11:0], chars};
        idxs[2] = CFG_FRAMES_PER_STEP;
        vals[2] = fps;
        idxs[3] = CFG_UNUSED;
        vals[3] = ~noise;
        cnt = touch_unused ? 4 : 3;
        for (int k = 0; k < cnt; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks so the scroll offset moves, with loads changing the picture under
    // it, the odd stop and the odd meaningless command. Bursts alternate with gaps.
    task automatic run_phase(input int count);
        int         done, burst, gap, pick;
        bit         paused;
        logic [1:0] cmd;
        done   = 0;
        burst  = $urandom_range(1, 12);
        paused = 1'b0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      cmd = CMD_TICK;
            else if (pick < 93) cmd = CMD_LOAD;
            else if (pick < 96) cmd = CMD_STOP;
            else                cmd = CMD_NONE;
            drive_item(cmd, 3'($urandom), 3'($urandom), 8'($urandom));
            if (cmd != CMD_NONE) done++;
            burst--;
            if (!paused && done >= count / 2) begin
                paused = 1'b1;
                wait_for_drain();
            end else if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 11) == 0) begin
                    wait_for_drain();
                end else if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (burst == 0)
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
        end
    endtask

    // Register settings per phase; the last one is drawn at random.
    logic [2:0]  plan_mode  [NUM_PHASES] = '{MODE_BOTTOM_UP, MODE_RIGHT_LEFT,
        MODE_LEFT_RIGHT, MODE_TOP_DOWN, MODE_TOP_DOWN, MODE_RIGHT_LEFT, MODE_UNUSED,
        MODE_LEFT_RIGHT, MODE_BOTTOM_UP, MODE_STATIC};
    logic [3:0]  plan_chars [NUM_PHASES] = '{4'd2, 4'd3, 4'd2, 4'd1, 4'd8, 4'd0, 4'd15,
        4'd8, 4'd9, 4'd1};
    logic [15:0] plan_fps   [NUM_PHASES] = '{16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0,
        16'hFFFF, 16'd2, 16'd1, 16'd1};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed start at the reset settings: corner pattern bytes, one static
        // frame, stops, a tick while blanked and a command that is ignored.
        drive_item(CMD_LOAD, 3'd0, 3'd0, 8'hFF);
        drive_item(CMD_LOAD, 3'd0, 3'd1, 8'h80);
        drive_item(CMD_LOAD, 3'd0, 3'd7, 8'h01);
        drive_item(CMD_LOAD, 3'd7, 3'd7, 8'hA5);
        drive_item(CMD_LOAD, 3'd3, 3'd4, 8'h5A);
        tick_rows(8);
        drive_item(CMD_STOP, 3'd7, 3'd7, 8'hFF);
        tick_rows(1);
        drive_item(CMD_NONE, 3'd7, 3'd7, 8'hFF);
        tick_rows(2);
        drive_item(CMD_STOP, 3'd0, 3'd0, 8'h00);
        drive_item(CMD_STOP, 3'd0, 3'd0, 8'h00);
        tick_rows(1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                plan_mode[p]  = 3'($urandom);
                plan_chars[p] = 4'($urandom);
                plan_fps[p]   = 16'($urandom_range(0, 3));
            end
            settle_idle();
            program_regs(plan_mode[p], plan_chars[p], plan_fps[p], p == 6);
            run_phase(PHASE_ITEMS);
        end

        settle_idle();
        $display("Run covered %0d loads, %0d ticks, %0d stops and %0d ignored commands",
                 sb.loads, sb.ticks, sb.stops, sb.ignored);
        $display("with %0d register writes; %0d row words checked, %0d offset steps, %0d wraps.",
                 sb.reg_writes, sb.rows_checked, sb.advances, sb.wraps);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d row words still owed.", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
